>>> rtl/rtxd_pkg.sv
// Package for the radix token XOR decoder: field widths, register indexes,
// the result record and the character-to-digit function.
// No dependencies; every other file of the block imports it.
package rtxd_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIX        = 2'd0,
    REG_XOR_KEY      = 2'd1,
    REG_SEPARATOR    = 2'd2,
    REG_TOKEN_DIGITS = 2'd3
  } rtxd_reg_e;

  // Register reset values.
  localparam logic [RadixW-1:0] RadixRst     = 6'd10;
  localparam logic [CharW-1:0]  XorKeyRst    = 8'd0;
  localparam logic [CharW-1:0]  SeparatorRst = 8'd32;
  localparam logic [CountW-1:0] TokDigitsRst = 7'd1;

  localparam logic [CountW-1:0] CountMax = 7'd127;

  // Digit code for a character that is not alphanumeric.
  localparam logic [RadixW-1:0] NotDigit = 6'd36;

  typedef struct packed {
    logic [CharW-1:0] out_byte;
    logic             bad_digit;
    logic             final_res;
  } rtxd_res_t;

  // Maps '0'-'9', 'a'-'z', 'A'-'Z' to 0-35 and anything else to 36.
  function automatic logic [RadixW-1:0] char_digit(input logic [CharW-1:0] c);
    logic [CharW-1:0] off;
    off = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      off = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      off = c - 8'h61 + 8'd10;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      off = c - 8'h41 + 8'd10;
    end else begin
      off = {2'b00, NotDigit};
    end
    return off[RadixW-1:0];
  endfunction

endpackage

>>> rtl/rtxd_if.sv
// Channel interfaces of the radix token XOR decoder: one for input
// characters, one for decoded results. Depends on rtxd_pkg.

interface rtxd_in_if;
  import rtxd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] in_char;
  logic             end_of_text;

  modport source (output valid, in_char, end_of_text, input ready);
  modport sink   (input valid, in_char, end_of_text, output ready);
endinterface

interface rtxd_out_if;
  import rtxd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_byte;
  logic             bad_digit;
  logic             final_res;

  modport source (output valid, out_byte, bad_digit, final_res, input ready);
  modport sink   (input valid, out_byte, bad_digit, final_res, output ready);
endinterface

>>> rtl/radix_token_xor_decoder.sv
// Top level of the radix token XOR decoder: token accumulation, close
// logic and a four-entry result queue. Depends on rtxd_pkg and rtxd_if.
//
//   Channel    Dir  Beat payload                          Handshake
//   item_i     in   in_char, end_of_text                  valid/ready
//   result_o   out  out_byte, bad_digit, final_res        valid/ready
//   cfg        in   cfg_idx_i, cfg_data_i                 cfg_we_i, no wait
//
// Each character is decoded in the cycle it is accepted, so one input beat can be
// taken every clock while the input is ready; its zero, one or two results land in
// the result queue at that same edge and appear on result_o from the next cycle on.
// The result queue drains one beat per cycle while result_o is ready, which sets
// the rate when items keep yielding two results. The input is ready while the queue
// has room for two results, so a stalled result side holds the input once three or
// more results wait; beats that close no token add nothing to the queue.
// Reset clears the token, the queue and loads the registers' default values.
module radix_token_xor_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rtxd_in_if.sink                      item_i,
  rtxd_out_if.source                   result_o,
  input  logic                         cfg_we_i,
  input  logic [rtxd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtxd_pkg::CfgW-1:0]    cfg_data_i
);
  import rtxd_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // Configuration registers.
  logic [RadixW-1:0] radix_q;
  logic [CharW-1:0]  xor_key_q;
  logic [CharW-1:0]  separator_q;
  logic [CountW-1:0] token_digits_q;

  // Token state.
  logic [CharW-1:0]  token_q, token_d;
  logic [CountW-1:0] count_q, count_d;

  // Result queue.
  rtxd_res_t       queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q, fill_d;

  logic        accept, pop;
  logic [1:0]  n_res;
  rtxd_res_t   res0, res1;

  logic              is_sep;
  logic [RadixW-1:0] digit;
  logic              bad;
  logic [13:0]       prod;
  logic [CharW-1:0]  acc;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] tok_len;
  logic              full_tok;

  // The input waits only while the queue cannot take two more results.
  assign item_i.ready = (fill_q <= CntW'(QDepth - 2));
  assign accept       = item_i.valid && item_i.ready;

  assign result_o.valid     = (fill_q != '0);
  assign result_o.out_byte  = queue_q[rd_ptr_q].out_byte;
  assign result_o.bad_digit = queue_q[rd_ptr_q].bad_digit;
  assign result_o.final_res = queue_q[rd_ptr_q].final_res;
  assign pop = result_o.valid && result_o.ready;

  // Decode of the character at the input: the multiply is 6 by 8 bits and only
  // the low byte of the accumulated value is ever kept.
  always_comb begin
    is_sep    = (separator_q != '0) && (item_i.in_char == separator_q);
    digit     = char_digit(item_i.in_char);
    bad       = (digit >= radix_q);
    prod      = {8'b0, radix_q} * {6'b0, token_q};
    acc       = prod[CharW-1:0] + {2'b00, digit};
    count_inc = (count_q == CountMax) ? CountMax : count_q + 7'd1;
    tok_len   = (token_digits_q == '0) ? 7'd1 : token_digits_q;
    full_tok  = (separator_q == '0) && (count_inc >= tok_len);

    token_d = token_q;
    count_d = count_q;
    n_res   = 2'd0;
    res0    = '{out_byte: acc ^ xor_key_q, bad_digit: 1'b0,
                final_res: item_i.end_of_text};
    res1    = '{out_byte: xor_key_q, bad_digit: 1'b0, final_res: 1'b1};

    if (accept) begin
      priority if (is_sep) begin
        // A separator closes the pending token; at end of text an empty
        // token follows it.
        res0.out_byte  = token_q ^ xor_key_q;
        res0.final_res = 1'b0;
        n_res   = item_i.end_of_text ? 2'd2 : 2'd1;
        token_d = '0;
        count_d = '0;
      end else if (bad) begin
        res0    = '{out_byte: '0, bad_digit: 1'b1, final_res: item_i.end_of_text};
        n_res   = 2'd1;
        token_d = '0;
        count_d = '0;
      end else if (full_tok || item_i.end_of_text) begin
        n_res   = 2'd1;
        token_d = '0;
        count_d = '0;
      end else begin
        token_d = acc;
        count_d = count_inc;
      end
    end
  end

  always_comb begin
    fill_d = fill_q + {1'b0, n_res} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q        <= RadixRst;
      xor_key_q      <= XorKeyRst;
      separator_q    <= SeparatorRst;
      token_digits_q <= TokDigitsRst;
    end else if (cfg_we_i) begin
      unique case (rtxd_reg_e'(cfg_idx_i))
        REG_RADIX:        radix_q        <= cfg_data_i[RadixW-1:0];
        REG_XOR_KEY:      xor_key_q      <= cfg_data_i;
        REG_SEPARATOR:    separator_q    <= cfg_data_i;
        REG_TOKEN_DIGITS: token_digits_q <= cfg_data_i[CountW-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q  <= '0;
      count_q  <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      token_q  <= token_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Queue payload carries no reset; entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      queue_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

endmodule
